// ===== sv/bae_pkg.sv =====
`default_nettype none
package bae_pkg;

  localparam int PRECISION_DEF   = 32;
  localparam int TOTAL_BITS_DEF  = 16;
  localparam int PENDING_MAX_DEF = 256;

  localparam int BEGIN_W = 16;
  localparam int FREQ_W  = 17;
  localparam int MAX_RES = 40;
  localparam int RES_W   = $clog2(MAX_RES + 1);
  localparam int ADDR_W  = $clog2(MAX_RES);
  localparam int BYTE_W  = 8;

  typedef struct packed {
    logic              start;
    logic [FREQ_W-1:0] f;
    logic [FREQ_W-1:0] t;
  } bae_ureq_t;

endpackage
`default_nettype wire

// ===== sv/bae_if.sv =====
`default_nettype none
interface bae_sym_if;
  logic        valid;
  logic        ready;
  logic [15:0] range_begin;
  logic [16:0] range_end;
  logic [16:0] freq_total;
  logic        final_symbol;

  modport source (output valid, range_begin, range_end, freq_total, final_symbol,
                  input ready);
  modport sink (input valid, range_begin, range_end, freq_total, final_symbol,
                output ready);
endinterface

interface bae_code_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       last_of_run;
  logic       stream_end;
  logic       pending_overflow;

  modport source (output valid, out_byte, last_of_run, stream_end, pending_overflow,
                  input ready);
  modport sink (input valid, out_byte, last_of_run, stream_end, pending_overflow,
                output ready);
endinterface
`default_nettype wire

// ===== sv/bae_ram.sv =====
`default_nettype none
module bae_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 40
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ===== sv/bae_muldiv.sv =====
`default_nettype none
module bae_muldiv #(
  parameter int PRECISION = bae_pkg::PRECISION_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire bae_pkg::bae_ureq_t    req,
  input  wire logic [PRECISION:0]    w,
  output logic                       done,
  output logic      [PRECISION:0]    result
);
  import bae_pkg::*;

  // rnd(w * f / t) = floor((2 * w * f + t) / (2 * t))
  localparam int QW = PRECISION + 1;
  localparam int PW = PRECISION + 1 + FREQ_W;
  localparam int DW = FREQ_W + 2;
  localparam int CW = $clog2(QW + 1);

  localparam logic [1:0] U_IDLE = 2'd0;
  localparam logic [1:0] U_MUL  = 2'd1;
  localparam logic [1:0] U_ADD  = 2'd2;
  localparam logic [1:0] U_DIV  = 2'd3;

  logic [1:0]        state;
  logic [CW-1:0]     cnt;
  logic [PW-1:0]     acc;
  logic [PW-1:0]     mcand;
  logic [FREQ_W-1:0] mplier;
  logic [FREQ_W-1:0] tot;
  logic [DW-2:0]     rem;
  logic [QW-1:0]     nsh;
  logic [DW-1:0]     dvs;
  logic [DW-1:0]     trial;
  logic [PW+1:0]     num;

  assign dvs   = {1'b0, tot, 1'b0};
  assign trial = {rem, nsh[QW-1]};
  assign num   = {1'b0, acc, 1'b0} + (PW + 2)'(tot);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= U_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        U_IDLE: begin
          if (req.start) begin
            acc    <= '0;
            mcand  <= PW'(w);
            mplier <= req.f;
            tot    <= req.t;
            cnt    <= CW'(FREQ_W);
            state  <= U_MUL;
          end
        end
        U_MUL: begin
          if (mplier[0]) begin
            acc <= acc + mcand;
          end
          mcand  <= mcand << 1;
          mplier <= mplier >> 1;
          cnt    <= cnt - 1'b1;
          if (cnt == CW'(1)) begin
            state <= U_ADD;
          end
        end
        U_ADD: begin
          rem   <= num[PW:QW];
          nsh   <= num[QW-1:0];
          cnt   <= CW'(QW);
          state <= U_DIV;
        end
        U_DIV: begin
          if (trial >= dvs) begin
            rem <= (DW - 1)'(trial - dvs);
            nsh <= {nsh[QW-2:0], 1'b1};
          end else begin
            rem <= trial[DW-2:0];
            nsh <= {nsh[QW-2:0], 1'b0};
          end
          cnt <= cnt - 1'b1;
          if (cnt == CW'(1)) begin
            done  <= 1'b1;
            state <= U_IDLE;
          end
        end
        default: state <= U_IDLE;
      endcase
    end
  end

  assign result = nsh;

endmodule
`default_nettype wire

// ===== sv/binary_arithmetic_encoder.sv =====
`default_nettype none
// the two scaled products are formed one after the other on the shared
// multiply/divide unit, followed by the rescaling steps and the emitted bits
// one symbol at a time: no new symbol is taken until its code bytes are delivered
// bytes of one symbol are collected in a 40-entry buffer before the first transfer
// reset (synchronous, rst high) restores the full interval and an empty bit packer
module binary_arithmetic_encoder #(
  parameter int PRECISION   = bae_pkg::PRECISION_DEF,
  parameter int TOTAL_BITS  = bae_pkg::TOTAL_BITS_DEF,
  parameter int PENDING_MAX = bae_pkg::PENDING_MAX_DEF
) (
  input wire logic    clk,
  input wire logic    rst,
  bae_sym_if.sink     sym,
  bae_code_if.source  code
);
  import bae_pkg::*;

  localparam int PCW = $clog2(PENDING_MAX + 1);
  localparam logic [PRECISION:0] ONE     = 1;
  localparam logic [PRECISION:0] WHOLE   = ONE << PRECISION;
  localparam logic [PRECISION:0] HALF    = ONE << (PRECISION - 1);
  localparam logic [PRECISION:0] QUARTER = ONE << (PRECISION - 2);
  localparam logic [PRECISION:0] THREE_Q = HALF + QUARTER;
  localparam logic [31:0] TOT_LIM = 32'd1 << TOTAL_BITS;

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_START_E = 4'd1;
  localparam logic [3:0] S_WAIT_E  = 4'd2;
  localparam logic [3:0] S_START_B = 4'd3;
  localparam logic [3:0] S_WAIT_B  = 4'd4;
  localparam logic [3:0] S_SCALE   = 4'd5;
  localparam logic [3:0] S_EMIT    = 4'd6;
  localparam logic [3:0] S_PAD     = 4'd7;
  localparam logic [3:0] S_OUT_RD  = 4'd8;
  localparam logic [3:0] S_OUT_LD  = 4'd9;
  localparam logic [3:0] S_OUT_HLD = 4'd10;

  logic [3:0]         state;
  logic [PRECISION:0] low;
  logic [PRECISION:0] high;
  logic [PCW-1:0]     pend;
  logic [BYTE_W-1:0]  acc;
  logic [2:0]         fill;
  logic [RES_W-1:0]   nres;
  logic [RES_W-1:0]   rd_idx;
  logic               oflow;
  logic               fin;
  logic               flushing;
  logic               emit_first;
  logic               bitv;
  logic [BEGIN_W-1:0] bg;
  logic [FREQ_W-1:0]  en;
  logic [FREQ_W-1:0]  tot;
  logic [PRECISION:0] nb;
  logic [PRECISION:0] na;
  logic [PRECISION:0] w;

  logic [FREQ_W-1:0]  t_in;
  logic [FREQ_W-1:0]  t_clamp;
  logic [FREQ_W-1:0]  en_clamp;
  bae_ureq_t          ureq;
  logic               udone;
  logic [PRECISION:0] ures;
  logic               emit_en;
  logic               emit_val;
  logic [BYTE_W-1:0]  acc_new;
  logic               ram_we;
  logic [BYTE_W-1:0]  ram_wdata;
  logic [BYTE_W-1:0]  ram_rdata;
  logic               accept;

  assign accept = sym.valid && sym.ready;
  assign sym.ready = (state == S_IDLE);

  always_comb begin
    t_in = (sym.freq_total == '0) ? FREQ_W'(1) : sym.freq_total;
    if (32'(t_in) > TOT_LIM) begin
      t_clamp = FREQ_W'(TOT_LIM);
    end else begin
      t_clamp = t_in;
    end
    en_clamp = (sym.range_end > t_clamp) ? t_clamp : sym.range_end;
  end

  assign w = high - low;
  assign ureq.start = (state == S_START_E) || (state == S_START_B);
  assign ureq.f     = (state == S_START_E) ? en : FREQ_W'(bg);
  assign ureq.t     = tot;
  assign na         = low + ures;

  bae_muldiv #(.PRECISION(PRECISION)) u_muldiv (
    .clk    (clk),
    .rst    (rst),
    .req    (ureq),
    .w      (w),
    .done   (udone),
    .result (ures)
  );

  assign emit_en  = (state == S_EMIT);
  assign emit_val = emit_first ? bitv : !bitv;
  assign acc_new  = acc | (BYTE_W'(emit_val) << fill);
  assign ram_we   = (nres < RES_W'(MAX_RES)) &&
                    ((emit_en && fill == 3'd7) || (state == S_PAD && fill != 3'd0));
  assign ram_wdata = emit_en ? acc_new : acc;

  bae_ram #(.WIDTH(BYTE_W), .DEPTH(MAX_RES)) u_buf (
    .clk   (clk),
    .we    (ram_we),
    .waddr (nres[ADDR_W-1:0]),
    .wdata (ram_wdata),
    .raddr (rd_idx[ADDR_W-1:0]),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      low        <= '0;
      high       <= WHOLE;
      pend       <= '0;
      acc        <= '0;
      fill       <= '0;
      nres       <= '0;
      rd_idx     <= '0;
      oflow      <= 1'b0;
      fin        <= 1'b0;
      flushing   <= 1'b0;
      emit_first <= 1'b0;
      code.valid <= 1'b0;
    end else begin
      if (ram_we) begin
        nres <= nres + 1'b1;
      end
      if (emit_en) begin
        if (fill == 3'd7) begin
          acc  <= '0;
          fill <= '0;
        end else begin
          acc  <= acc_new;
          fill <= fill + 1'b1;
        end
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            bg       <= sym.range_begin;
            en       <= en_clamp;
            tot      <= t_clamp;
            fin      <= sym.final_symbol;
            nres     <= '0;
            rd_idx   <= '0;
            oflow    <= 1'b0;
            flushing <= 1'b0;
            state    <= (FREQ_W'(sym.range_begin) < en_clamp) ? S_START_E : S_SCALE;
          end
        end
        S_START_E: state <= S_WAIT_E;
        S_WAIT_E: begin
          if (udone) begin
            nb    <= na;
            state <= S_START_B;
          end
        end
        S_START_B: state <= S_WAIT_B;
        S_WAIT_B: begin
          if (udone) begin
            if (na < nb) begin
              low  <= na;
              high <= nb;
            end
            state <= S_SCALE;
          end
        end
        S_SCALE: begin
          if (high < HALF) begin
            low        <= low << 1;
            high       <= high << 1;
            bitv       <= 1'b0;
            emit_first <= 1'b1;
            state      <= S_EMIT;
          end else if (low > HALF) begin
            low        <= (low - HALF) << 1;
            high       <= (high - HALF) << 1;
            bitv       <= 1'b1;
            emit_first <= 1'b1;
            state      <= S_EMIT;
          end else if (low > QUARTER && high < THREE_Q) begin
            if (pend >= PCW'(PENDING_MAX)) begin
              oflow <= 1'b1;
            end else begin
              pend <= pend + 1'b1;
            end
            low  <= (low - QUARTER) << 1;
            high <= (high - QUARTER) << 1;
          end else if (fin) begin
            if (pend >= PCW'(PENDING_MAX)) begin
              oflow <= 1'b1;
            end else begin
              pend <= pend + 1'b1;
            end
            bitv       <= (low > QUARTER);
            emit_first <= 1'b1;
            flushing   <= 1'b1;
            state      <= S_EMIT;
          end else begin
            state <= S_OUT_RD;
          end
        end
        S_EMIT: begin
          emit_first <= 1'b0;
          if (emit_first ? (pend == '0) : (pend == PCW'(1))) begin
            state <= flushing ? S_PAD : S_SCALE;
          end
          if (!emit_first) begin
            pend <= pend - 1'b1;
          end
        end
        S_PAD: begin
          low   <= '0;
          high  <= WHOLE;
          pend  <= '0;
          acc   <= '0;
          fill  <= '0;
          state <= S_OUT_RD;
        end
        S_OUT_RD: begin
          state <= (nres == '0) ? S_IDLE : S_OUT_LD;
        end
        S_OUT_LD: begin
          code.valid            <= 1'b1;
          code.out_byte         <= ram_rdata;
          code.last_of_run      <= (rd_idx == nres - 1'b1);
          code.stream_end       <= fin && (rd_idx == nres - 1'b1);
          code.pending_overflow <= oflow;
          state                 <= S_OUT_HLD;
        end
        S_OUT_HLD: begin
          if (code.ready) begin
            code.valid <= 1'b0;
            rd_idx     <= rd_idx + 1'b1;
            state      <= (rd_idx == nres - 1'b1) ? S_IDLE : S_OUT_RD;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_valid_hold: assert property (@(posedge clk) disable iff (rst)
    code.valid |-> state == S_OUT_HLD)
    else $error("result shown outside hold state");
  a_res_limit: assert property (@(posedge clk) disable iff (rst)
    nres <= RES_W'(MAX_RES))
    else $error("byte buffer count beyond limit");
  a_pend_limit: assert property (@(posedge clk) disable iff (rst)
    pend <= PCW'(PENDING_MAX))
    else $error("pending count beyond saturation");
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    accept |=> state != S_IDLE)
    else $error("symbol transfer did not start work");

endmodule
`default_nettype wire

// ===== bench/binary_arithmetic_encoder_test.sv =====
`timescale 1ns / 100ps
module binary_arithmetic_encoder_test;
  import bae_pkg::*;

  localparam int PREC = PRECISION_DEF;
  localparam int TBITS = TOTAL_BITS_DEF;
  localparam int PMAX = PENDING_MAX_DEF;
  localparam logic [63:0] WHOLE = 64'd1 << PREC;
  localparam logic [63:0] HALF = 64'd1 << (PREC - 1);
  localparam logic [63:0] QUARTER = 64'd1 << (PREC - 2);
  localparam logic [63:0] THREE_Q = 3 * QUARTER;
  localparam int CYCLE_LIMIT = 1000000;

  typedef struct packed {
    logic [7:0] code_byte;
    logic       run_last;
    logic       end_flag;
    logic       oflow;
  } code_byte_t;

  logic clk = 0;
  logic rst = 1;
  always #2 clk = ~clk;

  bae_sym_if sym ();
  bae_code_if code ();

  binary_arithmetic_encoder DUT (.clk(clk), .rst(rst), .sym(sym), .code(code));

  logic [63:0] iv_low, iv_high;
  int unsigned pend;
  logic [7:0] acc;
  int unsigned fill;
  code_byte_t run_bytes[$];
  code_byte_t expected_bytes[$];
  logic run_oflow;

  int errors = 0;
  int cycles = 0;
  int hold_cycles = 0;
  int send_gap_max = 3;

  initial begin
    sym.valid = 0;
    sym.range_begin = 0;
    sym.range_end = 0;
    sym.freq_total = 0;
    sym.final_symbol = 0;
    code.ready = 0;
  end

  task automatic report(input string what, input code_byte_t got, input code_byte_t exp);
    $display("mismatch %s: got %h exp %h", what, got, exp);
    errors++;
  endtask

  task automatic model_reset();
    iv_low = 0;
    iv_high = WHOLE;
    pend = 0;
    acc = 0;
    fill = 0;
  endtask

  task automatic pack_bit(input logic b);
    code_byte_t r;
    acc[fill] = b;
    fill++;
    if (fill == 8) begin
      r = '0;
      r.code_byte = acc;
      if (run_bytes.size() < MAX_RES) run_bytes.push_back(r);
      acc = 0;
      fill = 0;
    end
  endtask

  task automatic emit_pending(input logic b);
    pack_bit(b);
    for (int i = 0; i < pend; i++) pack_bit(~b);
    pend = 0;
  endtask

  task automatic bump_pending();
    if (pend >= PMAX) begin
      pend = PMAX;
      run_oflow = 1;
    end else pend++;
  endtask

  function automatic logic [63:0] scaled(input logic [63:0] w, input logic [63:0] f,
                                         input logic [63:0] t);
    logic [63:0] q, r;
    q = w / t;
    r = w % t;
    return q * f + (2 * r * f + t) / (2 * t);
  endfunction

  task automatic encode_symbol(input logic [15:0] bg_in, input logic [16:0] en_in,
                               input logic [16:0] t_in, input logic fin);
    logic [63:0] bg, en, t, w, na, nb;
    bg = bg_in;
    en = en_in;
    t = t_in;
    run_bytes.delete();
    run_oflow = 0;
    if (t == 0) t = 1;
    if (t > (64'd1 << TBITS)) t = 64'd1 << TBITS;
    if (en > t) en = t;
    if (bg < en) begin
      w = iv_high - iv_low;
      nb = iv_low + scaled(w, en, t);
      na = iv_low + scaled(w, bg, t);
      if (na < nb) begin
        iv_low = na;
        iv_high = nb;
      end
    end
    forever begin
      if (iv_high < HALF) emit_pending(0);
      else if (iv_low > HALF) begin
        emit_pending(1);
        iv_low -= HALF;
        iv_high -= HALF;
      end else if (iv_low > QUARTER && iv_high < THREE_Q) begin
        bump_pending();
        iv_low -= QUARTER;
        iv_high -= QUARTER;
      end else break;
      iv_low *= 2;
      iv_high *= 2;
    end
    if (fin) begin
      bump_pending();
      emit_pending(iv_low <= QUARTER ? 1'b0 : 1'b1);
      if (fill != 0) begin
        if (run_bytes.size() < MAX_RES) run_bytes.push_back(code_byte_t'({acc, 3'b000}));
        acc = 0;
        fill = 0;
      end
    end
    foreach (run_bytes[k]) begin
      run_bytes[k].oflow = run_oflow;
      if (k == run_bytes.size() - 1) begin
        run_bytes[k].run_last = 1;
        run_bytes[k].end_flag = fin;
      end
      expected_bytes.push_back(run_bytes[k]);
    end
    if (fin) model_reset();
  endtask

  function automatic int gap_len(input int maxg);
    if ($urandom_range(0, 9) == 0) return int'($urandom_range(0, maxg * 6));
    return int'($urandom_range(0, maxg));
  endfunction

  task automatic send_symbol(input logic [15:0] bg, input logic [16:0] en,
                             input logic [16:0] t, input logic fin);
    int g;
    g = (send_gap_max == 0) ? 0 : gap_len(send_gap_max);
    if (g > 0) begin
      sym.valid <= 0;
      repeat (g) @(posedge clk);
    end
    sym.valid <= 1;
    sym.range_begin <= bg;
    sym.range_end <= en;
    sym.freq_total <= t;
    sym.final_symbol <= fin;
    @(posedge clk);
    while (!sym.ready) @(posedge clk);
    encode_symbol(bg, en, t, fin);
  endtask

  task automatic idle_sender();
    sym.valid <= 0;
    @(posedge clk);
  endtask

  task automatic wait_drained();
    idle_sender();
    while (expected_bytes.size() != 0) @(posedge clk);
  endtask

  // receiver with random stalls and long holds
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (rst) code.ready <= 0;
    else if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      code.ready <= 0;
    end else if ($urandom_range(0, 3) == 0) code.ready <= ($urandom_range(0, 19) == 0) ? 0 : 1;
    else if ($urandom_range(0, 2) == 0) code.ready <= ~code.ready;
  end

  always @(posedge clk) begin
    code_byte_t got, exp;
    if (!rst && code.valid && code.ready) begin
      got = {code.out_byte, code.last_of_run, code.stream_end, code.pending_overflow};
      if (expected_bytes.size() == 0) begin
        report("unexpected transfer", got, '0);
      end else begin
        exp = expected_bytes.pop_front();
        if (got.code_byte !== exp.code_byte) report("out_byte", got, exp);
        if (got.run_last !== exp.run_last) report("last_of_run", got, exp);
        if (got.end_flag !== exp.end_flag) report("stream_end", got, exp);
        if (got.oflow !== exp.oflow) report("pending_overflow", got, exp);
      end
    end
  end

  always @(posedge clk) begin
    if (cycles > CYCLE_LIMIT) begin
      $display("[binary_arithmetic_encoder] ERROR");
      $finish;
    end
  end

  task automatic test_directed();
    send_symbol(16'd0, 17'd1, 17'd2, 0);
    send_symbol(16'd1, 17'd2, 17'd2, 0);
    send_symbol(16'd0, 17'd65536, 17'd65536, 0);
    send_symbol(16'd65535, 17'd65536, 17'd65536, 0);
    send_symbol(16'd0, 17'd1, 17'd65536, 0);
    send_symbol(16'd0, 17'd1, 17'd0, 0);
    send_symbol(16'd3, 17'd100, 17'h1ffff, 0);
    send_symbol(16'd5, 17'd131071, 17'd10, 0);
    send_symbol(16'd9, 17'd9, 17'd20, 0);
    send_symbol(16'hffff, 17'd3, 17'd20, 0);
    send_symbol(16'd32767, 17'd32769, 17'd65536, 0);
    send_symbol(16'd1, 17'd2, 17'd3, 1);
    send_symbol(16'd0, 17'd1, 17'd1, 1);
    send_symbol(16'd0, 17'd0, 17'd0, 1);
    wait_drained();
  endtask

  // long run of middle symbols saturates the pending count
  task automatic test_pending_saturation();
    for (int i = 0; i < 20; i++)
      send_symbol(16'd32767, 17'd32769, 17'd65536, 0);
    send_symbol(16'd0, 17'd1, 17'd65536, 1);
    wait_drained();
  endtask

  task automatic test_backpressure();
    hold_cycles = 3000;
    send_gap_max = 0;
    for (int i = 0; i < 20; i++)
      send_symbol(16'($urandom_range(0, 1000)), 17'($urandom_range(1001, 2000)), 17'd2000, 0);
    send_symbol(16'd0, 17'd1, 17'd3, 1);
    send_gap_max = 3;
    wait_drained();
  endtask

  task automatic test_random();
    logic [16:0] t, en;
    logic [15:0] bg;
    for (int i = 0; i < 280; i++) begin
      case ($urandom_range(0, 9))
        0: begin
          t = 17'($urandom());
          en = 17'($urandom());
          bg = 16'($urandom());
        end
        1: begin
          t = 17'($urandom_range(1, 4));
          bg = 16'($urandom_range(0, t - 1));
          en = 17'(bg) + 17'd1;
        end
        default: begin
          t = 17'($urandom_range(1, 65536));
          bg = 16'($urandom_range(0, t - 1));
          en = 17'($urandom_range(bg + 1, t));
        end
      endcase
      send_symbol(bg, en, t, $urandom_range(0, 24) == 0);
      if (i == 140) wait_drained();
    end
    send_symbol(16'd0, 17'd1, 17'd2, 1);
    wait_drained();
  endtask

  initial begin
    model_reset();
    repeat (2) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    test_directed();
    test_pending_saturation();
    test_backpressure();
    test_random();
    repeat (400) @(posedge clk);
    if (errors == 0 && expected_bytes.size() == 0)
      $display("[binary_arithmetic_encoder] OK");
    else
      $display("[binary_arithmetic_encoder] ERROR");
    $finish;
  end
endmodule
